// ===== design/bb3_pkg.sv =====
// Shared types, constants and helpers of the 3x3 RGB555 box blur.
`timescale 1ns / 1ps
`default_nettype none

package bb3_pkg;

	localparam int MAX_WIDTH_DEF = 512;

	localparam int PIX_W      = 16;
	localparam int CHAN_W     = 5;
	localparam int SUM_W      = 9;   // up to nine 5-bit values
	localparam int RECIP_W    = 13;
	localparam int RECIP_SH   = 12;
	localparam int WIDTH_W    = 10;
	localparam int HEIGHT_W   = 13;
	localparam int ROW_W      = 14;  // row position may run to height + 1 while draining
	localparam int CFG_DATA_W = 13;
	localparam int LINE_W     = 2 * PIX_W;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 10'd512;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd512;

	typedef enum logic [0:0] {
		OP_PUSH  = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	// Per-pixel work handed to the averaging stage.
	typedef struct packed {
		logic [SUM_W-1:0]   sum_r;
		logic [SUM_W-1:0]   sum_g;
		logic [SUM_W-1:0]   sum_b;
		logic [RECIP_W-1:0] recip;
		logic               last;
	} avg_in_t;

	// ceil(2^12 / n) for the neighbour counts that occur; exact for sums up to 279.
	function automatic logic [RECIP_W-1:0] avg_recip(input logic [1:0] rows,
		input logic [1:0] cols);
		logic [3:0] n;
		logic [RECIP_W-1:0] m;
		n = {2'b00, rows} * {2'b00, cols};
		unique case (n)
			4'd2:    m = 13'd2048;
			4'd3:    m = 13'd1366;
			4'd4:    m = 13'd1024;
			4'd6:    m = 13'd683;
			4'd9:    m = 13'd456;
			default: m = 13'd4096;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== design/bb3_ifs.sv =====
// Stream and configuration channel interfaces of the box blur.
`timescale 1ns / 1ps
`default_nettype none

interface bb3_pix_in_if;
	logic                         valid;
	logic                         ready;
	bb3_pkg::op_t                 operation;
	logic [bb3_pkg::PIX_W-1:0]    pixel;

	modport source (output valid, output operation, output pixel, input ready);
	modport sink   (input valid, input operation, input pixel, output ready);
endinterface

interface bb3_pix_out_if;
	logic                         valid;
	logic                         ready;
	logic [bb3_pkg::PIX_W-1:0]    blurred_pixel;
	logic                         last;

	modport source (output valid, output blurred_pixel, output last, input ready);
	modport sink   (input valid, input blurred_pixel, input last, output ready);
endinterface

interface bb3_cfg_if;
	logic                            valid;
	logic                            ready;
	bb3_pkg::reg_idx_t               index;
	logic [bb3_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/bb3_line_mem.sv =====
// Line store memory: previous two rows per column, with read-during-write bypass.
`timescale 1ns / 1ps
`default_nettype none

module bb3_line_mem #(
	parameter int DEPTH  = bb3_pkg::MAX_WIDTH_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       re,
	input  wire logic [ADDR_W-1:0]          raddr,
	input  wire logic                       we,
	input  wire logic [ADDR_W-1:0]          waddr,
	input  wire logic [bb3_pkg::LINE_W-1:0] wdata,
	output logic      [bb3_pkg::LINE_W-1:0] rdata
);

	logic [bb3_pkg::LINE_W-1:0] mem [DEPTH];
	logic [bb3_pkg::LINE_W-1:0] rd_q;
	logic [bb3_pkg::LINE_W-1:0] byp_data_q;
	logic                       byp_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_q       <= mem[raddr];
			byp_data_q <= wdata;
		end
	end

	// read and write of the same entry in one cycle: take the new data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (re) begin
			byp_q <= we && (waddr == raddr);
		end
	end

	assign rdata = byp_q ? byp_data_q : rd_q;

endmodule

`default_nettype wire

// ===== design/bb3_avg.sv =====
// Averaging stage: divides the channel sums by the neighbour count and packs the pixel.
`timescale 1ns / 1ps
`default_nettype none

module bb3_avg (
	input  wire logic                      clk,
	input  wire logic                      ld,
	input  wire bb3_pkg::avg_in_t          din,
	output logic      [bb3_pkg::PIX_W-1:0] pixel_q,
	output logic                           last_q
);

	localparam int PROD_W = bb3_pkg::SUM_W + bb3_pkg::RECIP_W;
	localparam int LSB    = bb3_pkg::RECIP_SH;
	localparam int MSB    = bb3_pkg::RECIP_SH + bb3_pkg::CHAN_W - 1;

	logic [PROD_W-1:0] prod_r, prod_g, prod_b;

	// multiply by the reciprocal, quotient is the product shifted down
	assign prod_r = PROD_W'(din.sum_r) * PROD_W'(din.recip);
	assign prod_g = PROD_W'(din.sum_g) * PROD_W'(din.recip);
	assign prod_b = PROD_W'(din.sum_b) * PROD_W'(din.recip);

	always_ff @(posedge clk) begin
		if (ld) begin
			pixel_q <= {1'b1, prod_b[MSB:LSB], prod_g[MSB:LSB], prod_r[MSB:LSB]};
			last_q  <= din.last;
		end
	end

endmodule

`default_nettype wire

// ===== design/box_blur_3x3_rgb555_core.sv =====
// Top level of the streaming 3x3 box blur over RGB555 pixels.
// Pixels enter in raster order, one per clock when the result side keeps up. An accepted
// item reads its column of the line store (a MAX_WIDTH x 32 memory holding the two rows
// above) at the accepting edge. The next stage shifts and sums the 3x3 window and writes
// the column back, and the stage after that divides into the output register. The result
// for pixel k is released by the item pushed width + 1 positions later; after the frame,
// drain items (or extra pushes) release the remaining width + 1 results, the last one
// flagged. Drain items during the frame are dropped. Neighbours outside the image are
// left out of the average, which truncates. Configuration writes set width (clamped to
// 1..MAX_WIDTH) or height (0 acts as 1) and restart the frame; the line store needs no
// clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module box_blur_3x3_rgb555_core #(
	parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	bb3_cfg_if.sink        cfg,
	bb3_pix_in_if.sink     pixels,
	bb3_pix_out_if.source  results
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WID_W = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W = (WID_W > bb3_pkg::WIDTH_W) ? WID_W : bb3_pkg::WIDTH_W;
	localparam int PIX_W = bb3_pkg::PIX_W;
	localparam int ROW_W = bb3_pkg::ROW_W;
	localparam int SUM_W = bb3_pkg::SUM_W;

	typedef struct packed {
		logic prod;
		logic last;
		logic r0;
		logic r1;
		logic c0;
		logic c1;
	} ctl_t;

	// configuration and raster position
	logic [bb3_pkg::WIDTH_W-1:0]  w_q;
	logic [bb3_pkg::HEIGHT_W-1:0] h_q;
	logic [COL_W-1:0]             col_q;
	logic [ROW_W-1:0]             row_q;

	logic [WID_W-1:0]             eff_w;
	logic [bb3_pkg::HEIGHT_W-1:0] eff_h;
	logic [ROW_W-1:0]             eff_h_ext;
	logic [CMP_W-1:0]             w_ext;
	logic                         in_frame;
	logic                         step;
	logic                         wrap;
	logic [COL_W-1:0]             ocol;
	logic [ROW_W-1:0]             orow;
	ctl_t                         ctl;
	logic [PIX_W-1:0]             px;
	logic                         accept;
	logic                         cfg_we;

	// pipeline
	logic                         v_s1;
	logic [COL_W-1:0]             addr_s1;
	logic [PIX_W-1:0]             px_s1;
	ctl_t                         ctl_s1;
	logic                         v_s2;
	bb3_pkg::avg_in_t             avg_s2;
	logic                         out_v_q;

	logic                         out_free, s2_free, s1_free, s1_go;
	logic [bb3_pkg::LINE_W-1:0]   line;
	logic [PIX_W-1:0]             above, above2;
	logic [PIX_W-1:0]             win_q [9];
	logic [PIX_W-1:0]             win_d [9];
	logic [2:0]                   rmask, cmask;
	bb3_pkg::avg_in_t             avg_d;

	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;

	// effective dimensions
	assign w_ext     = CMP_W'(w_q);
	assign eff_w     = (w_q == '0) ? WID_W'(1) :
		(w_ext > CMP_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : WID_W'(w_ext);
	assign eff_h     = (h_q == '0) ? bb3_pkg::HEIGHT_W'(1) : h_q;
	assign eff_h_ext = ROW_W'(eff_h);

	assign in_frame = row_q < eff_h_ext;
	assign step     = !((pixels.operation == bb3_pkg::OP_DRAIN) && in_frame);
	assign px       = in_frame ? pixels.pixel : '0;
	assign wrap     = (WID_W'(col_q) + WID_W'(1)) >= eff_w;

	// center of the window that this item completes
	always_comb begin
		ctl.prod = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && (col_q != '0));
		if (col_q == '0) begin
			orow = row_q - ROW_W'(2);
			ocol = COL_W'(eff_w - WID_W'(1));
		end else begin
			orow = row_q - ROW_W'(1);
			ocol = col_q - COL_W'(1);
		end
		ctl.c0   = ocol != '0;
		ctl.c1   = (WID_W'(ocol) + WID_W'(1)) < eff_w;
		ctl.r0   = orow != '0;
		ctl.r1   = (orow + ROW_W'(1)) < eff_h_ext;
		ctl.last = ctl.prod && (orow == eff_h_ext - ROW_W'(1))
			&& (WID_W'(ocol) == eff_w - WID_W'(1));
	end

	// handshake between stages
	assign out_free     = !out_v_q || results.ready;
	assign s2_free      = !v_s2 || out_free;
	assign s1_free      = !v_s1 || s2_free;
	assign s1_go        = v_s1 && s2_free;
	assign pixels.ready = s1_free;
	assign accept       = pixels.valid && pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= bb3_pkg::WIDTH_RESET;
			h_q   <= bb3_pkg::HEIGHT_RESET;
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg.index)
				bb3_pkg::REG_IMAGE_WIDTH:  w_q <= cfg.data[bb3_pkg::WIDTH_W-1:0];
				bb3_pkg::REG_IMAGE_HEIGHT: h_q <= cfg.data[bb3_pkg::HEIGHT_W-1:0];
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (accept && step) begin
			priority if (ctl.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	bb3_line_mem #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (COL_W)
	) u_line (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (accept && step),
		.raddr  (col_q),
		.we     (s1_go),
		.waddr  (addr_s1),
		.wdata  ({above, px_s1}),
		.rdata  (line)
	);

	assign above  = line[PIX_W-1:0];
	assign above2 = line[2*PIX_W-1:PIX_W];

	// window shift and masked channel sums
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_d[i*3]   = win_q[i*3+1];
			win_d[i*3+1] = win_q[i*3+2];
		end
		win_d[2] = above2;
		win_d[5] = above;
		win_d[8] = px_s1;

		rmask = {ctl_s1.r1, 1'b1, ctl_s1.r0};
		cmask = {ctl_s1.c1, 1'b1, ctl_s1.c0};
		avg_d.sum_r = '0;
		avg_d.sum_g = '0;
		avg_d.sum_b = '0;
		for (int y = 0; y < 3; y++) begin
			for (int x = 0; x < 3; x++) begin
				if (rmask[y] && cmask[x]) begin
					avg_d.sum_r = avg_d.sum_r + SUM_W'(win_d[y*3+x][4:0]);
					avg_d.sum_g = avg_d.sum_g + SUM_W'(win_d[y*3+x][9:5]);
					avg_d.sum_b = avg_d.sum_b + SUM_W'(win_d[y*3+x][14:10]);
				end
			end
		end
		avg_d.recip = bb3_pkg::avg_recip(2'd1 + 2'(ctl_s1.r0) + 2'(ctl_s1.r1),
			2'd1 + 2'(ctl_s1.c0) + 2'(ctl_s1.c1));
		avg_d.last  = ctl_s1.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= '0;
			end
		end else begin
			if (s1_free) begin
				v_s1 <= accept && step;
			end
			if (s2_free) begin
				v_s2 <= v_s1 && ctl_s1.prod;
			end
			if (out_free) begin
				out_v_q <= v_s2;
			end
			if (s1_go) begin
				win_q <= win_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= col_q;
			px_s1   <= px;
			ctl_s1  <= ctl;
		end
		if (s1_go) begin
			avg_s2 <= avg_d;
		end
	end

	bb3_avg u_avg (
		.clk     (clk),
		.ld      (out_free && v_s2),
		.din     (avg_s2),
		.pixel_q (results.blurred_pixel),
		.last_q  (results.last)
	);

	assign results.valid = out_v_q;

	// column position stays inside the active width
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		WID_W'(col_q) < eff_w)
		else $error("column position beyond image width");

	// row position never passes the drain row after the frame
	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= eff_h_ext + ROW_W'(1))
		else $error("row position beyond frame plus drain row");

	// the final result of a frame restarts the raster position
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && step && ctl.last) |=> (col_q == '0 && row_q == '0))
		else $error("frame did not restart after its last pixel");

	// a result entering the output register came from a stage that held one
	a_out_from_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(out_free && !v_s2) |=> !out_v_q)
		else $error("output valid without a pending result");

endmodule

`default_nettype wire
